FILE: design/assert_macros.svh
// Assertion macros shared by the sampler RTL.
// Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KVS_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assert failed");
`define KVS_IMPLIES(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assert failed");
`else
`define KVS_ASSERT(label, cond)
`define KVS_IMPLIES(label, pre, post)
`endif
`endif

FILE: design/kvs_pkg.sv
// Package for the keyframe vector sampler: sizes, codes, queue entry and state types.
// No dependencies.
package kvs_pkg;
  localparam int MaxKeys = 64;
  localparam int IdxW = $clog2(MaxKeys);
  localparam int CntW = 7;

  localparam logic [1:0] HitInside = 2'd0;
  localparam logic [1:0] HitBefore = 2'd1;
  localparam logic [1:0] HitAfter  = 2'd2;
  localparam logic [1:0] HitEmpty  = 2'd3;

  localparam logic KindLoad  = 1'b0;
  localparam logic KindQuery = 1'b1;

  localparam logic [0:0] RegInterpMode = 1'd0;
  localparam logic [0:0] RegKeyCount   = 1'd1;

  typedef struct packed {
    logic             kind;
    logic [IdxW-1:0]  key_index;
    logic [31:0]      time_value;
    logic [31:0]      in_x;
    logic [31:0]      in_y;
    logic [31:0]      in_z;
  } item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_CHK0, S_RDL, S_CHKL, S_SCAN, S_SCANW, S_DIV,
    S_MUL, S_SUM, S_EMIT, S_OUT
  } state_t;
endpackage

FILE: design/kvs_if.sv
// Valid/ready channel interface carrying one payload of type T.
// Depends on nothing.
interface kvs_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: design/kvs_out_t.sv
// Result payload type for the sampler output channel.
// Standalone package for the output struct.
package kvs_out_pkg;
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         where_hit;
  } result_t;
endpackage

FILE: design/kvs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module kvs_ram #(parameter int Width = 32, parameter int Depth = 64) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: design/kvs_front.sv
// Front end: accepts items and queues them in a two-entry FIFO for the back end.
// Uses kvs_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kvs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  kvs_pkg::item_t in_data,
  output logic           q_valid,
  input  logic           q_pop,
  output kvs_pkg::item_t q_data
);
  import kvs_pkg::*;
  item_t    slots [2];
  logic     wptr, rptr;
  logic [1:0] fill;
  logic     push;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_data   = slots[rptr];

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop && q_valid) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end

  // hold payloads
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= in_data;
  end

  `KVS_ASSERT(a_fill_max, fill != 2'd3)
  `KVS_IMPLIES(a_full_stall, fill == 2'd2, !in_ready)
  `KVS_IMPLIES(a_ptr_eq, fill == 2'd0, wptr == rptr)
endmodule

FILE: design/kvs_div.sv
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
// No package needed.
module kvs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);
  logic [32:0] rem;
  logic [47:0] q;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial    = {rem[31:0], q[47]} - {1'b0, dsr};
  assign quotient = q;

  // step one bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        q   <= {q[46:0], 1'b1};
      end else begin
        rem <= {rem[31:0], q[47]};
        q   <= {q[46:0], 1'b0};
      end
    end
  end
endmodule

FILE: design/kvs_back.sv
// Back end: key table, segment search, divider and blend; drives one result register.
// Uses kvs_pkg, kvs_out_pkg, kvs_ram and kvs_div.
`include "assert_macros.svh"
module kvs_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  kvs_pkg::item_t          q_data,
  input  logic                    interp_mode,
  input  logic [6:0]              key_count,
  output logic                    out_valid,
  input  logic                    out_ready,
  output kvs_out_pkg::result_t    out_data
);
  import kvs_pkg::*;
  import kvs_out_pkg::*;

  state_t state, state_next;
  logic [IdxW-1:0] raddr, scan_i, scan_i_next;
  logic [31:0] rd_t, rd_x, rd_y, rd_z;
  logic [31:0] t0, x0, y0, z0;
  logic [31:0] tq;
  logic [IdxW:0] nkeys;
  logic [IdxW-1:0] last_i;
  logic we;
  logic [1:0] comp;
  logic signed [63:0] acc [3];
  logic signed [63:0] prod_p, prod_n;
  logic [15:0] a_frac;
  logic div_start, div_done;
  logic [47:0] div_q;
  logic [31:0] px, py, pz;
  result_t res, res_next;
  logic out_load;

  assign we = (state == S_IDLE) && q_valid && (q_data.kind == KindLoad);
  assign nkeys = (key_count > 7'(MaxKeys)) ? (IdxW+1)'(MaxKeys) : key_count[IdxW:0];
  assign last_i = IdxW'(nkeys - 1'b1);

  kvs_ram #(.Width(32), .Depth(MaxKeys)) u_t (.clk, .we, .waddr(q_data.key_index),
    .wdata(q_data.time_value), .raddr, .rdata(rd_t));
  kvs_ram #(.Width(32), .Depth(MaxKeys)) u_x (.clk, .we, .waddr(q_data.key_index),
    .wdata(q_data.in_x), .raddr, .rdata(rd_x));
  kvs_ram #(.Width(32), .Depth(MaxKeys)) u_y (.clk, .we, .waddr(q_data.key_index),
    .wdata(q_data.in_y), .raddr, .rdata(rd_y));
  kvs_ram #(.Width(32), .Depth(MaxKeys)) u_z (.clk, .we, .waddr(q_data.key_index),
    .wdata(q_data.in_z), .raddr, .rdata(rd_z));

  kvs_div u_div (.clk, .rst, .start(div_start), .dividend({tq - t0, 16'd0}),
    .divisor(rd_t - t0), .done(div_done), .quotient(div_q));

  // one component's two products per cycle
  always_comb begin
    case (comp)
      2'd0: begin prod_p = $signed(x0) * $signed({1'b0, 17'(17'h10000 - a_frac)});
                  prod_n = $signed(px) * $signed({1'b0, a_frac}); end
      2'd1: begin prod_p = $signed(y0) * $signed({1'b0, 17'(17'h10000 - a_frac)});
                  prod_n = $signed(py) * $signed({1'b0, a_frac}); end
      default: begin prod_p = $signed(z0) * $signed({1'b0, 17'(17'h10000 - a_frac)});
                  prod_n = $signed(pz) * $signed({1'b0, a_frac}); end
    endcase
  end

  function automatic logic [31:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) return 32'h7FFFFFFF;
    if (r < -64'sd2147483648) return 32'h80000000;
    return r[31:0];
  endfunction

  // sequence the search and blend
  always_comb begin
    state_next  = state;
    scan_i_next = scan_i;
    raddr       = scan_i;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    res_next    = res;
    out_load    = 1'b0;
    case (state)
      S_IDLE: if (q_valid) begin
        q_pop = 1'b1;
        if (q_data.kind == KindQuery) begin
          if (nkeys == '0) begin
            res_next = '{32'sd0, 32'sd0, 32'sd0, HitEmpty};
            state_next = S_OUT;
          end else begin
            raddr = '0;
            state_next = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (tq <= rd_t) begin
          res_next = '{rd_x, rd_y, rd_z, HitBefore};
          state_next = S_OUT;
        end else begin
          raddr = last_i;
          state_next = S_CHKL;
        end
      end
      S_CHKL: begin
        if (tq >= rd_t) begin
          res_next = '{rd_x, rd_y, rd_z, HitAfter};
          state_next = S_OUT;
        end else begin
          raddr = '0;
          scan_i_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        // rd holds entry scan_i; fetch scan_i+1
        raddr = scan_i + 1'b1;
        state_next = S_SCANW;
      end
      S_SCANW: begin
        // rd holds entry scan_i+1, t0 holds entry scan_i
        if (tq >= t0 && tq < rd_t) begin
          if (!interp_mode) begin
            res_next = '{x0, y0, z0, HitInside};
            state_next = S_OUT;
          end else begin
            div_start = 1'b1;
            state_next = S_DIV;
          end
        end else if ({1'b0, scan_i} + 2'd2 >= nkeys) begin
          raddr = '0;
          state_next = S_EMIT;
        end else begin
          scan_i_next = scan_i + 1'b1;
          raddr = scan_i + 1'b1;
          state_next = S_SCAN;
        end
      end
      S_EMIT: begin
        res_next = '{rd_x, rd_y, rd_z, HitInside};
        state_next = S_OUT;
      end
      S_DIV: begin
        raddr = scan_i + 1'b1;
        if (div_done) state_next = S_MUL;
      end
      S_MUL: begin
        raddr = scan_i + 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        raddr = scan_i + 1'b1;
        if (comp == 2'd2) begin
          res_next = '{sat(acc[0]), sat(acc[1]), sat(acc[2]), HitInside};
          state_next = S_OUT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_OUT: if (!out_valid || out_ready) begin
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // hold datapath values
  always_ff @(posedge clk) begin
    res    <= res_next;
    scan_i <= scan_i_next;
    if (out_load) out_data <= res;
    if (state == S_IDLE) tq <= q_data.time_value;
    if (state == S_SCAN || state == S_CHKL) begin
      t0 <= rd_t; x0 <= rd_x; y0 <= rd_y; z0 <= rd_z;
    end
    if (state == S_DIV && div_done) begin
      a_frac <= (div_q > 48'd65535) ? 16'hFFFF : div_q[15:0];
      px <= rd_x; py <= rd_y; pz <= rd_z;
      comp <= 2'd0;
    end
    if (state == S_MUL) acc[comp] <= prod_p + prod_n;
    if (state == S_SUM && comp != 2'd2) comp <= comp + 2'd1;
  end

  `KVS_IMPLIES(a_pop_idle, q_pop, state == S_IDLE)
  `KVS_IMPLIES(a_out_hold, out_valid && !out_ready && state == S_OUT, !out_load)
  `KVS_IMPLIES(a_load_hit, out_load, res.where_hit != HitEmpty || res.out_x == 32'sd0)
endmodule

FILE: design/keyframe_vector_sampler_core.sv
// Keyframe vector sampler. Loads write one key (time, x, y, z) into a 64-entry table and
// are taken by the back end in its idle state. A query returns the first key when it
// lands at or before that key and the last key when it lands at or after that one;
// otherwise a sequential search over the segments follows. Linear mode then runs the
// 48-step bit-serial divider and the three multiply-add passes. A two-entry queue lets
// new items arrive while a query runs; one item is worked at a time.
// Uses kvs_pkg, kvs_if, kvs_front and kvs_back.
module keyframe_vector_sampler_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  kvs_if.sink        in_ch,
  kvs_if.source      out_ch
);
  import kvs_pkg::*;
  logic  interp_mode;
  logic [6:0] key_count;
  logic  q_valid, q_pop;
  item_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= 1'b1;
      key_count   <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegInterpMode: interp_mode <= cfg_data[0];
        RegKeyCount:   key_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  kvs_front u_front (.clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_data(in_ch.data), .q_valid, .q_pop, .q_data);

  kvs_back u_back (.clk, .rst, .q_valid, .q_pop, .q_data, .interp_mode, .key_count,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
endmodule

FILE: dv/tb.sv
// Testbench for keyframe_vector_sampler_core: loads key tables, queries the track and
// checks every sample against an in-bench predictor of the sampler.
// Depends on kvs_pkg, kvs_out_pkg and kvs_if from the design folder.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvs_pkg::*;
  import kvs_out_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = RegInterpMode;
  logic [6:0] cfg_data = '0;

  kvs_if #(.T(item_t))   req_ch (clk);
  kvs_if #(.T(result_t)) smp_ch (clk);

  keyframe_vector_sampler_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(req_ch.sink), .out_ch(smp_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: key table and configuration
  logic [31:0] trk_time [MaxKeys];
  logic [31:0] trk_x [MaxKeys];
  logic [31:0] trk_y [MaxKeys];
  logic [31:0] trk_z [MaxKeys];
  logic        mode_q = 1'b1;
  int          nkeys_q = 0;
  result_t     samples_due [$];
  int          mismatches = 0;
  bit          stall_ok = 1'b1;
  int          idle_left = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    smp_ch.ready = 1'b0;
  end

  function automatic logic [31:0] blend_comp(logic [31:0] p, logic [31:0] n,
                                             longint unsigned frac);
    longint v;
    longint r;
    v = longint'($signed(p)) * longint'(65536 - frac) + longint'($signed(n)) * longint'(frac)
        + 64'sd32768;
    r = v >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic result_t pick_key(int k, logic [1:0] hit);
    result_t r;
    r.out_x = trk_x[k];
    r.out_y = trk_y[k];
    r.out_z = trk_z[k];
    r.where_hit = hit;
    return r;
  endfunction

  function automatic result_t sample_track(logic [31:0] t);
    result_t r;
    int seg;
    longint unsigned d;
    longint unsigned frac;
    seg = -1;
    if (nkeys_q == 0) begin
      r = '0;
      r.where_hit = HitEmpty;
      return r;
    end
    if (t <= trk_time[0]) return pick_key(0, HitBefore);
    if (t >= trk_time[nkeys_q-1]) return pick_key(nkeys_q - 1, HitAfter);
    for (int i = 0; i + 1 < nkeys_q; i++) begin
      if (seg < 0 && t >= trk_time[i] && t < trk_time[i+1]) seg = i;
    end
    // non-ascending table with no segment found: hold the first key
    if (seg < 0) return pick_key(0, HitInside);
    if (!mode_q) return pick_key(seg, HitInside);
    d = longint'(trk_time[seg+1]) - longint'(trk_time[seg]);
    frac = ((longint'(t) - longint'(trk_time[seg])) << 16) / d;
    if (frac > 65535) frac = 65535;
    r.out_x = blend_comp(trk_x[seg], trk_x[seg+1], frac);
    r.out_y = blend_comp(trk_y[seg], trk_y[seg+1], frac);
    r.out_z = blend_comp(trk_z[seg], trk_z[seg+1], frac);
    r.where_hit = HitInside;
    return r;
  endfunction

  // send one request and update the predictor on acceptance; valid stays high
  // when the next request follows with no gap
  task automatic send_req(logic kind, logic [5:0] idx, logic [31:0] t,
                          logic [31:0] x = 0, logic [31:0] y = 0, logic [31:0] z = 0);
    item_t it;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.kind = kind;
    it.key_index = idx;
    it.time_value = t;
    it.in_x = x;
    it.in_y = y;
    it.in_z = z;
    req_ch.valid <= 1'b1;
    req_ch.data <= it;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind == KindLoad) begin
      trk_time[idx] = t;
      trk_x[idx] = x;
      trk_y[idx] = y;
      trk_z[idx] = z;
    end else begin
      samples_due.push_back(sample_track(t));
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegInterpMode) mode_q = val[0];
    else nkeys_q = val > MaxKeys ? MaxKeys : val;
  endtask

  // load n ascending keys with random values; step between times is random
  task automatic load_track(int n, int span);
    logic [31:0] t;
    t = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      send_req(KindLoad, i, t, $urandom, $urandom, $urandom);
      t = t + 1 + $urandom_range(0, span);
    end
  endtask

  function automatic logic [31:0] pick_time();
    int k;
    k = $urandom_range(0, nkeys_q > 0 ? nkeys_q - 1 : 0);
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return nkeys_q > 0 ? trk_time[k] : 32'd0;
      2: return nkeys_q > 0 ? trk_time[k] + 1 : 32'd5;
      default: return nkeys_q > 0 ? trk_time[k] + $urandom_range(0, 70000) : $urandom;
    endcase
  endfunction

  // sample checker; after each sample, drop ready for a random number of cycles while stall_ok is set
  always @(posedge clk) begin
    result_t exp_s;
    if (smp_ch.valid && smp_ch.ready) begin
      if (samples_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %h", smp_ch.data);
      end else begin
        exp_s = samples_due.pop_front();
        if (smp_ch.data !== exp_s) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: exp x=%h y=%h z=%h hit=%0d got x=%h y=%h z=%h hit=%0d",
                     exp_s.out_x, exp_s.out_y, exp_s.out_z, exp_s.where_hit,
                     smp_ch.data.out_x, smp_ch.data.out_y, smp_ch.data.out_z,
                     smp_ch.data.where_hit);
        end
      end
    end
    if (rst) begin
      smp_ch.ready <= 1'b0;
    end else if (smp_ch.valid && smp_ch.ready) begin
      idle_left = stall_ok ? $urandom_range(0, 12) : 0;
      smp_ch.ready <= (idle_left == 0);
    end else if (idle_left > 0) begin
      idle_left--;
      smp_ch.ready <= (idle_left == 0);
    end else begin
      smp_ch.ready <= 1'b1;
    end
  end

  task automatic test_empty_track();
    write_reg(RegKeyCount, 0);
    send_req(KindQuery, 0, 32'h0);
    send_req(KindQuery, 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_single_key();
    send_req(KindLoad, 0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    write_reg(RegKeyCount, 1);
    send_req(KindQuery, 0, 32'h0);
    send_req(KindQuery, 0, 32'h0001_0000);
    send_req(KindQuery, 0, 32'hFFFF_FFFF);
  endtask

  task automatic test_extremes();
    // full-scale values on both sides of a segment, then queries between them in both modes
    send_req(KindLoad, 0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
    send_req(KindLoad, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_req(KindLoad, 2, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    write_reg(RegKeyCount, 3);
    send_req(KindQuery, 0, 32'h4000_0000);
    send_req(KindQuery, 0, 32'h7FFF_FFFF);
    send_req(KindQuery, 0, 32'h8000_0001);
    send_req(KindQuery, 0, 32'hFFFF_FFFE);
    write_reg(RegInterpMode, 0);
    send_req(KindQuery, 0, 32'h4000_0000);
    send_req(KindQuery, 0, 32'hC000_0000);
    write_reg(RegInterpMode, 1);
  endtask

  task automatic test_unordered();
    // times out of order: the search takes the first segment that holds the query time
    send_req(KindLoad, 0, 32'd100, 32'd1, 32'd2, 32'd3);
    send_req(KindLoad, 1, 32'd500, 32'd4, 32'd5, 32'd6);
    send_req(KindLoad, 2, 32'd200, 32'd7, 32'd8, 32'd9);
    send_req(KindLoad, 3, 32'd900, 32'd10, 32'd11, 32'd12);
    write_reg(RegKeyCount, 4);
    send_req(KindQuery, 0, 32'd600);
    send_req(KindQuery, 0, 32'd300);
  endtask

  task automatic test_full_table();
    load_track(64, 3000);
    write_reg(RegKeyCount, 64);
    for (int i = 0; i < 60; i++) send_req(KindQuery, $urandom, pick_time());
    // count above the table size is clamped
    write_reg(RegKeyCount, 7'd127);
    for (int i = 0; i < 20; i++) send_req(KindQuery, $urandom, pick_time());
  endtask

  task automatic test_random_tracks();
    int n;
    for (int r = 0; r < 34; r++) begin
      n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 64) : $urandom_range(1, 8);
      write_reg(RegInterpMode, $urandom_range(0, 1));
      load_track(n, $urandom_range(0, 1) ? 200 : 32'h0100_0000);
      write_reg(RegKeyCount, n);
      stall_ok = (r % 5) != 4;
      for (int i = 0; i < 12; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_req(KindLoad, $urandom_range(n, 63), $urandom, $urandom, $urandom, $urandom);
        else
          send_req(KindQuery, $urandom, pick_time());
      end
      stall_ok = 1'b1;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_track();
    test_single_key();
    test_extremes();
    test_unordered();
    test_full_table();
    // hold off until every sample is back
    req_ch.valid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    test_random_tracks();
    drain();
    if (mismatches == 0 && samples_due.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #3ms;
    $display("tb NOT OK");
    $finish;
  end
endmodule
